// ----- src/http_chunked_body_decoder_top_defines.svh -----
// Assertion macros shared by the chunked body decoder RTL.
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge, reset included.
`define HCBD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

// Check a property only while out of reset.
`define HCBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`else

`define HCBD_ASSERT_ALWAYS(lbl, prop, msg)
`define HCBD_ASSERT(lbl, prop, msg)

`endif

`endif

// ----- src/hcbd_pkg.sv -----
// Types, constants and helper functions for the chunked body decoder.
`default_nettype none

package hcbd_pkg;

    localparam int SIZE_BITS_DEFAULT = 31;
    localparam int HEX_BITS          = 4;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [7:0] CHAR_SP   = 8'h20;
    localparam logic [7:0] CHAR_TAB  = 8'h09;

    typedef enum logic [2:0] {
        PH_SIZE = 3'd0,
        PH_EXT  = 3'd1,
        PH_DATA = 3'd2,
        PH_CR   = 3'd3,
        PH_LF   = 3'd4,
        PH_IDLE = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_LINE  = 2'd0,
        ERR_TRUNC = 2'd1,
        ERR_CRLF  = 2'd2
    } err_t;

    typedef struct packed {
        phase_t phase;
        logic   digit_seen;
        logic   space_after;
        logic   cr_pending;
    } hcbd_state_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] data;
        err_t       code;
    } hcbd_result_t;

    typedef struct packed {
        logic                ok;
        logic [HEX_BITS-1:0] val;
    } hex_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SP) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = '0;
        if (c >= "0" && c <= "9") begin
            h.val = HEX_BITS'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            h.val = HEX_BITS'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            h.val = HEX_BITS'(c - "A" + 8'd10);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ----- src/hcbd_step.sv -----
// Next-state and result logic for one body byte of the chunked decoder.
`default_nettype none

module hcbd_step import hcbd_pkg::*; #(
    parameter int SIZE_BITS = SIZE_BITS_DEFAULT
) (
    input  logic [7:0]           body_byte,
    input  logic                 final_byte,
    input  hcbd_state_t          state_cur,
    input  logic [SIZE_BITS-1:0] size_cur,
    output hcbd_state_t          state_next,
    output logic [SIZE_BITS-1:0] size_next,
    output hcbd_result_t         result
);

    hex_t hx;
    logic sad_eff;
    logic line_bad;
    logic fin;
    kind_t fin_kind;
    err_t  fin_code;

    always_comb begin
        hx         = hex_decode(body_byte);
        sad_eff    = state_cur.space_after;
        line_bad   = 1'b0;
        fin        = 1'b0;
        fin_kind   = KIND_DONE;
        fin_code   = ERR_LINE;
        state_next = state_cur;
        size_next  = size_cur;
        result.valid = 1'b0;
        result.kind  = KIND_DATA;
        result.data  = '0;
        result.code  = ERR_LINE;

        case (state_cur.phase)
            PH_SIZE, PH_EXT: begin
                if (state_cur.cr_pending && body_byte == CHAR_LF) begin
                    state_next.cr_pending = 1'b0;
                    if (!state_cur.digit_seen) begin
                        fin      = 1'b1;
                        fin_kind = KIND_ERR;
                        fin_code = ERR_LINE;
                    end else if (size_cur == '0) begin
                        fin      = 1'b1;
                        fin_kind = KIND_DONE;
                    end else if (final_byte) begin
                        fin      = 1'b1;
                        fin_kind = KIND_ERR;
                        fin_code = ERR_TRUNC;
                    end else begin
                        state_next.phase       = PH_DATA;
                        state_next.digit_seen  = 1'b0;
                        state_next.space_after = 1'b0;
                    end
                end else begin
                    // a CR not followed by LF counts as whitespace
                    sad_eff = state_cur.space_after | (state_cur.cr_pending &
                              state_cur.digit_seen & (state_cur.phase == PH_SIZE));
                    state_next.space_after = sad_eff;
                    state_next.cr_pending  = 1'b0;
                    if (body_byte == CHAR_CR) begin
                        state_next.cr_pending = 1'b1;
                    end else if (state_cur.phase == PH_EXT) begin
                        line_bad = 1'b0;
                    end else if (body_byte == CHAR_SEMI) begin
                        if (!state_cur.digit_seen) begin
                            line_bad = 1'b1;
                        end else begin
                            state_next.phase = PH_EXT;
                        end
                    end else if (is_space(body_byte)) begin
                        if (state_cur.digit_seen) begin
                            state_next.space_after = 1'b1;
                        end
                    end else if (!hx.ok || sad_eff ||
                                 size_cur[SIZE_BITS-1 -: HEX_BITS] != '0) begin
                        // bad character, digit after trailing space, or overflow
                        line_bad = 1'b1;
                    end else begin
                        size_next = {size_cur[SIZE_BITS-HEX_BITS-1:0], hx.val};
                        state_next.digit_seen = 1'b1;
                    end
                    if (line_bad) begin
                        fin      = 1'b1;
                        fin_kind = KIND_ERR;
                        fin_code = ERR_LINE;
                    end else if (final_byte) begin
                        fin      = 1'b1;
                        fin_kind = KIND_ERR;
                        fin_code = ERR_TRUNC;
                    end
                end
            end
            PH_DATA: begin
                if (final_byte) begin
                    fin      = 1'b1;
                    fin_kind = KIND_ERR;
                    fin_code = ERR_TRUNC;
                end else begin
                    size_next = size_cur - SIZE_BITS'(1);
                    if (size_cur == SIZE_BITS'(1)) begin
                        state_next.phase = PH_CR;
                    end
                    result.valid = 1'b1;
                    result.kind  = KIND_DATA;
                    result.data  = body_byte;
                end
            end
            PH_CR: begin
                if (body_byte != CHAR_CR) begin
                    fin      = 1'b1;
                    fin_kind = KIND_ERR;
                    fin_code = ERR_CRLF;
                end else if (final_byte) begin
                    fin      = 1'b1;
                    fin_kind = KIND_ERR;
                    fin_code = ERR_TRUNC;
                end else begin
                    state_next.phase = PH_LF;
                end
            end
            PH_LF: begin
                if (body_byte != CHAR_LF) begin
                    fin      = 1'b1;
                    fin_kind = KIND_ERR;
                    fin_code = ERR_CRLF;
                end else if (final_byte) begin
                    fin      = 1'b1;
                    fin_kind = KIND_ERR;
                    fin_code = ERR_TRUNC;
                end else begin
                    state_next.phase       = PH_SIZE;
                    state_next.digit_seen  = 1'b0;
                    state_next.space_after = 1'b0;
                    state_next.cr_pending  = 1'b0;
                    size_next              = '0;
                end
            end
            default: begin
                // drop bytes until the end of the body
                if (final_byte) begin
                    state_next.phase       = PH_SIZE;
                    state_next.digit_seen  = 1'b0;
                    state_next.space_after = 1'b0;
                    state_next.cr_pending  = 1'b0;
                    size_next              = '0;
                end
            end
        endcase

        if (fin) begin
            result.valid = 1'b1;
            result.kind  = fin_kind;
            result.data  = '0;
            result.code  = (fin_kind == KIND_ERR) ? fin_code : ERR_LINE;
            state_next.phase       = final_byte ? PH_SIZE : PH_IDLE;
            state_next.digit_seen  = 1'b0;
            state_next.space_after = 1'b0;
            state_next.cr_pending  = 1'b0;
            size_next              = '0;
        end
    end

endmodule

`default_nettype wire

// ----- src/http_chunked_body_decoder_top.sv -----
// Top level of the HTTP chunked transfer-coding body decoder.
//
//   channel | ports               | direction | carries
//   --------+---------------------+-----------+-----------------------------------
//   s_      | s_valid/s_ready     | in        | s_body_byte, s_final_byte
//   m_      | m_valid/m_ready     | out       | m_result_kind, m_data_byte, m_error_code
//
// One byte per cycle while m_ready allows: a request lands in the input register,
// then the parse logic updates the phase/size state and, for bytes that yield a
// result, fills the result register from it.
// Reset (aresetn low, synchronous) empties both registers and returns to the
// start of a size line. A stalled m_ready holds the result register, and the
// input register holds one more request behind it before s_ready drops.
`default_nettype none
`include "http_chunked_body_decoder_top_defines.svh"

module http_chunked_body_decoder_top import hcbd_pkg::*; #(
    parameter int SIZE_BITS = SIZE_BITS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_body_byte,
    input  logic       s_final_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_result_kind,
    output logic [7:0] m_data_byte,
    output logic [1:0] m_error_code
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_final_reg;
    hcbd_state_t          state_reg;
    hcbd_state_t          state_next;
    logic [SIZE_BITS-1:0] size_reg;
    logic [SIZE_BITS-1:0] size_next;
    hcbd_result_t         res;
    logic                 m_valid_reg;
    kind_t                kind_reg;
    logic [7:0]           data_reg;
    err_t                 code_reg;
    logic                 process;

    assign process = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || process;

    hcbd_step #(.SIZE_BITS(SIZE_BITS)) u_step (
        .body_byte  (in_byte_reg),
        .final_byte (in_final_reg),
        .state_cur  (state_reg),
        .size_cur   (size_reg),
        .state_next (state_next),
        .size_next  (size_next),
        .result     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_body_byte;
            in_final_reg <= s_final_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase       <= PH_SIZE;
            state_reg.digit_seen  <= 1'b0;
            state_reg.space_after <= 1'b0;
            state_reg.cr_pending  <= 1'b0;
            size_reg              <= '0;
        end else if (process) begin
            state_reg <= state_next;
            size_reg  <= size_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (process) begin
            m_valid_reg <= res.valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // load payload only when a result is produced
    always_ff @(posedge aclk) begin
        if (process && res.valid) begin
            kind_reg <= res.kind;
            data_reg <= res.data;
            code_reg <= res.code;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = kind_reg;
    assign m_data_byte   = data_reg;
    assign m_error_code  = code_reg;

    `HCBD_ASSERT(a_end_resets_phase, (process && res.valid && res.kind != KIND_DATA) |=> (state_reg.phase == PH_SIZE || state_reg.phase == PH_IDLE), "end of body did not leave the size or idle phase")
    `HCBD_ASSERT(a_data_from_data_phase, (process && res.valid && res.kind == KIND_DATA) |-> (state_reg.phase == PH_DATA), "data byte emitted outside the data phase")
    `HCBD_ASSERT(a_data_count_nonzero, (state_reg.phase == PH_DATA) |-> (size_reg != '0), "data phase with no bytes left")
    `HCBD_ASSERT(a_cr_only_on_line, state_reg.cr_pending |-> (state_reg.phase == PH_SIZE || state_reg.phase == PH_EXT), "pending CR outside a size line")
    `HCBD_ASSERT_ALWAYS(a_ready_only_blocked, (aresetn && !s_ready) |-> (in_valid_reg && m_valid_reg && !m_ready), "input stalled while the pipeline could move")

endmodule

`default_nettype wire
